// ----- hdl/tpmc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the two-player move clock.
// No dependencies; every other file refers to it by scoped names.
package tpmc_pkg;

    typedef logic [22:0] time_t;
    typedef logic [3:0][3:0] digits_t;  // element 0 is the leftmost digit

    // run state codes
    localparam logic [1:0] RUN_STOP = 2'd0;
    localparam logic [1:0] RUN_A    = 2'd1;
    localparam logic [1:0] RUN_B    = 2'd2;

    // increment modes
    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_FIXED_ADD = 2'd1;
    localparam logic [1:0] MODE_CAPPED    = 2'd2;

    typedef enum logic [1:0] {
        REG_START_TIME    = 2'd0,
        REG_INCREMENT     = 2'd1,
        REG_INC_MODE      = 2'd2,
        REG_RESTART_DELAY = 2'd3
    } cfg_index_t;

    localparam time_t       TIME_MAX       = 23'd5999000;
    localparam time_t       MINUTE_MS      = 23'd60000;
    localparam time_t       START_RESET    = 23'd300000;
    localparam logic [15:0] DELAY_RESET    = 16'd5000;

    localparam logic [3:0]  CODE_DASH      = 4'd10;
    localparam logic [3:0]  CODE_BLANK     = 4'd15;

    // reciprocals for constant division: q = (x * RECIP) >> SHIFT
    localparam logic [23:0] RECIP_1000     = 24'd8589935;
    localparam int          SHIFT_1000     = 33;
    localparam logic [16:0] RECIP_10       = 17'd104858;
    localparam int          SHIFT_10       = 20;
    localparam logic [13:0] RECIP_60       = 14'd8739;
    localparam int          SHIFT_60       = 19;
    localparam logic [13:0] RECIP_100      = 14'd10486;
    localparam int          SHIFT_100      = 20;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctl_t;

    // Split a value below 100 into {tens, ones}.
    function automatic logic [7:0] split_tens(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {8'b0, value} * 15'd205;
        tens = prod[14:11];
        ones = value - {tens, 3'b0} - {2'b0, tens, 1'b0};
        return {tens, ones[3:0]};
    endfunction

endpackage

// ----- hdl/tpmc_state.sv -----
`timescale 1ns / 1ps
// Clock state and configuration registers: tick, presses, increment, auto restart.
// Depends on tpmc_pkg.
module tpmc_state (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                tick,
    input  logic                press_a,
    input  logic                press_b,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [22:0]         cfg_data,
    output logic [1:0]          run_state,
    output tpmc_pkg::time_t     time_a,
    output tpmc_pkg::time_t     time_b
);

    tpmc_pkg::time_t start_time_reg;
    logic [15:0]     increment_reg;
    logic [1:0]      inc_mode_reg;
    logic [15:0]     restart_delay_reg;

    logic [1:0]      running_reg,    running_next;
    tpmc_pkg::time_t remain_a_reg,   remain_a_next;
    tpmc_pkg::time_t remain_b_reg,   remain_b_next;
    tpmc_pkg::time_t move_start_reg, move_start_next;
    logic [31:0]     elapsed_reg,    elapsed_next;
    logic [31:0]     flag_time_reg,  flag_time_next;

    tpmc_pkg::time_t load_time;

    function automatic logic [15:0] bonus(input logic [1:0] run,
                                          input tpmc_pkg::time_t mstart,
                                          input tpmc_pkg::time_t own,
                                          input logic [1:0] mode,
                                          input logic [15:0] inc);
        tpmc_pkg::time_t used;
        logic [15:0]     result;
        used   = (mstart > own) ? (mstart - own) : '0;
        result = '0;
        if (run != tpmc_pkg::RUN_STOP) begin
            if (mode == tpmc_pkg::MODE_FIXED_ADD) begin
                result = inc;
            end else if (mode == tpmc_pkg::MODE_CAPPED) begin
                result = (used < {7'b0, inc}) ? used[15:0] : inc;
            end
        end
        return result;
    endfunction

    function automatic tpmc_pkg::time_t sat_add(input tpmc_pkg::time_t a,
                                                input logic [15:0] b);
        logic [23:0] sum;
        sum = {1'b0, a} + {8'b0, b};
        return (sum > {1'b0, tpmc_pkg::TIME_MAX}) ? tpmc_pkg::TIME_MAX : sum[22:0];
    endfunction

    assign load_time = (start_time_reg > tpmc_pkg::TIME_MAX) ? tpmc_pkg::TIME_MAX
                                                             : start_time_reg;

    always_comb begin
        running_next    = running_reg;
        remain_a_next   = remain_a_reg;
        remain_b_next   = remain_b_reg;
        move_start_next = move_start_reg;
        elapsed_next    = elapsed_reg;
        flag_time_next  = flag_time_reg;

        // tick first: count down the running side, stop at zero
        if (tick) begin
            elapsed_next = elapsed_reg + 32'd1;
            if (running_reg == tpmc_pkg::RUN_A) begin
                if (remain_a_next != '0) remain_a_next = remain_a_next - 23'd1;
                if (remain_a_next == '0) begin
                    running_next   = tpmc_pkg::RUN_STOP;
                    flag_time_next = elapsed_next;
                end
            end else if (running_reg == tpmc_pkg::RUN_B) begin
                if (remain_b_next != '0) remain_b_next = remain_b_next - 23'd1;
                if (remain_b_next == '0) begin
                    running_next   = tpmc_pkg::RUN_STOP;
                    flag_time_next = elapsed_next;
                end
            end
        end

        // button A ends A's move
        if (press_a && running_next != tpmc_pkg::RUN_B &&
            remain_a_next != '0 && remain_b_next != '0) begin
            remain_a_next   = sat_add(remain_a_next,
                                      bonus(running_next, move_start_next, remain_a_next,
                                            inc_mode_reg, increment_reg));
            running_next    = tpmc_pkg::RUN_B;
            move_start_next = remain_b_next;
        end

        // then button B
        if (press_b && running_next != tpmc_pkg::RUN_A &&
            remain_a_next != '0 && remain_b_next != '0) begin
            remain_b_next   = sat_add(remain_b_next,
                                      bonus(running_next, move_start_next, remain_b_next,
                                            inc_mode_reg, increment_reg));
            running_next    = tpmc_pkg::RUN_A;
            move_start_next = remain_a_next;
        end

        // flag fallen and delay passed: restore start times
        if (running_next == tpmc_pkg::RUN_STOP &&
            (remain_a_next == '0 || remain_b_next == '0) &&
            (elapsed_next - flag_time_next) > {16'b0, restart_delay_reg}) begin
            running_next    = tpmc_pkg::RUN_STOP;
            remain_a_next   = load_time;
            remain_b_next   = load_time;
            move_start_next = load_time;
            flag_time_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= tpmc_pkg::RUN_STOP;
            remain_a_reg   <= tpmc_pkg::START_RESET;
            remain_b_reg   <= tpmc_pkg::START_RESET;
            move_start_reg <= tpmc_pkg::START_RESET;
            elapsed_reg    <= '0;
            flag_time_reg  <= '0;
        end else if (accept) begin
            running_reg    <= running_next;
            remain_a_reg   <= remain_a_next;
            remain_b_reg   <= remain_b_next;
            move_start_reg <= move_start_next;
            elapsed_reg    <= elapsed_next;
            flag_time_reg  <= flag_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg    <= tpmc_pkg::START_RESET;
            increment_reg     <= '0;
            inc_mode_reg      <= tpmc_pkg::MODE_NONE;
            restart_delay_reg <= tpmc_pkg::DELAY_RESET;
        end else if (cfg_valid) begin
            unique case (tpmc_pkg::cfg_index_t'(cfg_index))
                tpmc_pkg::REG_START_TIME:    start_time_reg    <= cfg_data;
                tpmc_pkg::REG_INCREMENT:     increment_reg     <= cfg_data[15:0];
                tpmc_pkg::REG_INC_MODE:      inc_mode_reg      <= cfg_data[1:0];
                tpmc_pkg::REG_RESTART_DELAY: restart_delay_reg <= cfg_data[15:0];
            endcase
        end
    end

    assign run_state = running_reg;
    assign time_a    = remain_a_reg;
    assign time_b    = remain_b_reg;

endmodule

// ----- hdl/tpmc_digits.sv -----
`timescale 1ns / 1ps
// Three-stage conversion of a millisecond time into four display digit codes.
// Depends on tpmc_pkg.
module tpmc_digits (
    input  logic                aclk,
    input  tpmc_pkg::pipe_ctl_t ctl,
    input  tpmc_pkg::time_t     time_in,
    output tpmc_pkg::digits_t   digits,
    output tpmc_pkg::time_t     time_out
);

    // stage 1: seconds and centiseconds
    logic [46:0]     prod_sec;
    logic [32:0]     prod_cs;
    logic [12:0]     sec_1_next, cs_1_next;
    logic [12:0]     sec_1_reg, cs_1_reg;
    logic            zero_1_reg, big_1_reg;
    tpmc_pkg::time_t time_1_reg;

    // stage 2: minutes and whole seconds below a minute
    logic [26:0]     prod_min;
    logic [26:0]     prod_q100;
    logic [6:0]      min_2_next, q100_2_next;
    logic [12:0]     sec_2_reg, cs_2_reg;
    logic [6:0]      min_2_reg, q100_2_reg;
    logic            zero_2_reg, big_2_reg;
    tpmc_pkg::time_t time_2_reg;

    // stage 3: digit codes
    logic [12:0]       mul60, mul100, lo_wide;
    logic [6:0]        hi, lo;
    logic [7:0]        hi_split, lo_split;
    tpmc_pkg::digits_t digits_next, digits_reg;
    tpmc_pkg::time_t   time_3_reg;

    assign prod_sec   = {24'b0, time_in} * {23'b0, tpmc_pkg::RECIP_1000};
    assign prod_cs    = {17'b0, time_in[15:0]} * {16'b0, tpmc_pkg::RECIP_10};
    assign sec_1_next = 13'(prod_sec >> tpmc_pkg::SHIFT_1000);
    assign cs_1_next  = 13'(prod_cs >> tpmc_pkg::SHIFT_10);

    always_ff @(posedge aclk) begin
        if (ctl.en1) begin
            sec_1_reg  <= sec_1_next;
            cs_1_reg   <= cs_1_next;
            zero_1_reg <= (time_in == '0);
            big_1_reg  <= (time_in >= tpmc_pkg::MINUTE_MS);
            time_1_reg <= time_in;
        end
    end

    assign prod_min    = {14'b0, sec_1_reg} * {13'b0, tpmc_pkg::RECIP_60};
    assign prod_q100   = {14'b0, cs_1_reg} * {13'b0, tpmc_pkg::RECIP_100};
    assign min_2_next  = 7'(prod_min >> tpmc_pkg::SHIFT_60);
    assign q100_2_next = 7'(prod_q100 >> tpmc_pkg::SHIFT_100);

    always_ff @(posedge aclk) begin
        if (ctl.en2) begin
            sec_2_reg  <= sec_1_reg;
            cs_2_reg   <= cs_1_reg;
            min_2_reg  <= min_2_next;
            q100_2_reg <= q100_2_next;
            zero_2_reg <= zero_1_reg;
            big_2_reg  <= big_1_reg;
            time_2_reg <= time_1_reg;
        end
    end

    // remainders by shift and add: x*60 = x*64 - x*4, x*100 = x*64 + x*32 + x*4
    assign mul60  = {min_2_reg, 6'b0} - {4'b0, min_2_reg, 2'b0};
    assign mul100 = {q100_2_reg, 6'b0} + {1'b0, q100_2_reg, 5'b0} + {4'b0, q100_2_reg, 2'b0};

    always_comb begin
        if (big_2_reg) begin
            lo_wide = sec_2_reg - mul60;
            hi      = min_2_reg;
        end else begin
            lo_wide = cs_2_reg - mul100;
            hi      = sec_2_reg[6:0];
        end
        lo       = lo_wide[6:0];
        hi_split = tpmc_pkg::split_tens(hi);
        lo_split = tpmc_pkg::split_tens(lo);

        if (zero_2_reg) begin
            digits_next = {4{tpmc_pkg::CODE_DASH}};
        end else begin
            digits_next[3] = lo_split[3:0];
            digits_next[2] = lo_split[7:4];
            digits_next[1] = (hi != '0) ? hi_split[3:0] : tpmc_pkg::CODE_BLANK;
            digits_next[0] = (hi >= 7'd10) ? hi_split[7:4] : tpmc_pkg::CODE_BLANK;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en3) begin
            digits_reg <= digits_next;
            time_3_reg <= time_2_reg;
        end
    end

    assign digits   = digits_reg;
    assign time_out = time_3_reg;

endmodule

// ----- hdl/two_player_move_clock_core.sv -----
`timescale 1ns / 1ps
// Top level of the two-player move clock: handshakes, stage valids, result packing.
// Depends on tpmc_pkg, tpmc_state and tpmc_digits.
//
// Usage:
//   Each input request on s_ carries a one-millisecond tick flag and the two
//   button levels. The clock state updates at the edge that accepts the request;
//   one result per request leaves on m_ with the run state, both remaining times
//   and the eight display digit codes computed from the updated state.
//   Configuration writes arrive on cfg_ (always ready). Increment, mode and
//   restart delay act on the next request; a new start time loads only at the
//   next automatic restart. Write only while no request is in flight.
//   Pipeline: the state register, then two conversion stages that hold the
//   reciprocal multipliers, then the output register. Throughput: one request
//   per cycle while the m_ side is not stalled.
//   Each stage advances when the stage after it is empty or moving, so a
//   stalled m_ side still lets the pipeline fill; s_tready drops only when all
//   four stages hold results.
//   Reset (aresetn low, synchronous) clears all valids, stops the clock and loads
//   300000 ms on both sides with the default configuration.
module two_player_move_clock_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] tick, [1] press_a, [2] press_b, rest zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [1:0] run_state, [5:2] left_digit0, [9:6] left_digit1,
                                   // [13:10] left_digit2, [17:14] left_digit3,
                                   // [21:18] right_digit0, [25:22] right_digit1,
                                   // [29:26] right_digit2, [33:30] right_digit3,
                                   // [56:34] time_a_ms, [79:57] time_b_ms

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    logic                accept;
    logic                en0;
    tpmc_pkg::pipe_ctl_t ctl;

    logic                v0_reg, v1_reg, v2_reg, m_valid_reg;
    logic [1:0]          run_state, run_1_reg, run_2_reg, run_3_reg;
    tpmc_pkg::time_t     time_a, time_b, time_a_out, time_b_out;
    tpmc_pkg::digits_t   digits_a, digits_b;

    // stage enables: advance when the next stage is empty or advancing
    assign ctl.en3  = !m_valid_reg || m_tready;
    assign ctl.en2  = !v2_reg || ctl.en3;
    assign ctl.en1  = !v1_reg || ctl.en2;
    assign en0      = !v0_reg || ctl.en1;
    assign s_tready = en0;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en0)     v0_reg      <= s_tvalid;
            if (ctl.en1) v1_reg      <= v0_reg;
            if (ctl.en2) v2_reg      <= v1_reg;
            if (ctl.en3) m_valid_reg <= v2_reg;
        end
    end

    // state registers double as the first stage's payload
    tpmc_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .tick      (s_tdata[0]),
        .press_a   (s_tdata[1]),
        .press_b   (s_tdata[2]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .run_state (run_state),
        .time_a    (time_a),
        .time_b    (time_b)
    );

    tpmc_digits u_digits_a (
        .aclk     (aclk),
        .ctl      (ctl),
        .time_in  (time_a),
        .digits   (digits_a),
        .time_out (time_a_out)
    );

    tpmc_digits u_digits_b (
        .aclk     (aclk),
        .ctl      (ctl),
        .time_in  (time_b),
        .digits   (digits_b),
        .time_out (time_b_out)
    );

    // carry the run state alongside the digit pipeline
    always_ff @(posedge aclk) begin
        if (ctl.en1) run_1_reg <= run_state;
        if (ctl.en2) run_2_reg <= run_1_reg;
        if (ctl.en3) run_3_reg <= run_2_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {time_b_out, time_a_out,
                       digits_b[3], digits_b[2], digits_b[1], digits_b[0],
                       digits_a[3], digits_a[2], digits_a[1], digits_a[0],
                       run_3_reg};

endmodule
